// File: sv/bmma_pkg.sv
// shared types and constants of the block matrix multiply-accumulate
package bmma_pkg;

  localparam int MAX_DIM  = 8;
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int ADDR_W   = $clog2(MAX_DIM * MAX_DIM);
  localparam int DATA_W   = 32;
  localparam int ROW_W    = 3;
  localparam int DIM_W    = 4;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 40;
  localparam int DRAIN_CYC = MAX_DIM + 3;
  localparam int DRAIN_W   = $clog2(DRAIN_CYC + 1);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MAC   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_EMIT  = 2'd3
  } opcode_t;

  // one A element traveling down the row of cells
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  k;
    logic [DATA_W-1:0] a;
  } tok_t;

  // B element load broadcast to the cells
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] b;
  } ld_t;

endpackage

// File: sv/bmma_ram.sv
// generic single write, single registered read memory
module bmma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/bmma_cell.sv
// one multiply-accumulate cell holding one column of B and of C
module bmma_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bmma_pkg::IDX_W-1:0]    col_id,
  input  logic [bmma_pkg::IDX_W-1:0]    d_last,
  input  bmma_pkg::ld_t                 ld,
  input  logic                          clr,
  input  bmma_pkg::tok_t                tok_in,
  output bmma_pkg::tok_t                tok_out,
  input  logic [bmma_pkg::IDX_W-1:0]    rd_row,
  output logic [bmma_pkg::DATA_W-1:0]   rd_data
);

  logic [bmma_pkg::DATA_W-1:0] b_col [bmma_pkg::MAX_DIM];
  logic [bmma_pkg::DATA_W-1:0] c_col [bmma_pkg::MAX_DIM];

  logic                        p_valid;
  logic                        p_first;
  logic                        p_last;
  logic [bmma_pkg::IDX_W-1:0]  p_row;
  logic [bmma_pkg::DATA_W-1:0] prod;
  logic [bmma_pkg::DATA_W-1:0] acc;
  logic                        s_valid;
  logic [bmma_pkg::IDX_W-1:0]  s_row;

  logic [bmma_pkg::IDX_W-1:0]  c_addr;
  logic [bmma_pkg::DATA_W-1:0] c_rd;
  logic                        col_en;

  assign c_addr  = s_valid ? s_row : rd_row;
  assign c_rd    = c_col[c_addr];
  assign rd_data = c_rd;
  assign col_en  = (col_id <= d_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      p_valid <= 1'b0;
      s_valid <= 1'b0;
      for (int r = 0; r < bmma_pkg::MAX_DIM; r++) begin
        c_col[r] <= '0;
      end
    end else begin
      tok_out <= tok_in;
      p_valid <= tok_in.valid;
      s_valid <= p_valid && p_last;
      if (clr) begin
        for (int r = 0; r < bmma_pkg::MAX_DIM; r++) begin
          c_col[r] <= '0;
        end
      end else if (s_valid && col_en) begin
        c_col[c_addr] <= c_rd + acc;
      end
    end
    // payload
    if (ld.valid && ld.col == col_id) begin
      b_col[ld.row] <= ld.b;
    end
    prod    <= tok_in.a * b_col[tok_in.k];
    p_first <= tok_in.first;
    p_last  <= tok_in.last;
    p_row   <= tok_in.row;
    s_row   <= p_row;
    if (p_valid) begin
      acc <= p_first ? prod : acc + prod;
    end
  end

endmodule

// File: sv/block_matrix_multiply_accumulate.sv
// top level: sequencer, A memory and the row of multiply-accumulate cells
// load and clear leave the sequencer idle; a new word is accepted in the next cycle
// multiply-accumulate does one A read per cycle from the A memory, then waits in
// the drain state for the trip down the cell row and the accumulate stages
// emit gives one word per cycle while downstream is ready, d*d words in all
// synchronous reset clears C, sets the dimension to 8 and empties the output
module block_matrix_multiply_accumulate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // row_index, col_index, a_value, b_value, zero pad
  input  logic [bmma_pkg::S_DATA_W-1:0]   s_tdata,
  // opcode
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // c_value, out_row, out_col, zero pad
  output logic [bmma_pkg::M_DATA_W-1:0]   m_tdata,
  // last_element
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  // dim_in_use
  input  logic [bmma_pkg::DIM_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t                          state;
  logic [bmma_pkg::DIM_W-1:0]      dim;
  logic [bmma_pkg::DIM_W-1:0]      dim_sat;
  logic [bmma_pkg::IDX_W-1:0]      d_last;
  logic [bmma_pkg::IDX_W-1:0]      cnt_i;
  logic [bmma_pkg::IDX_W-1:0]      cnt_j;
  logic [bmma_pkg::DRAIN_W-1:0]    drain;

  logic                            iss_valid;
  logic                            iss_first;
  logic                            iss_last;
  logic [bmma_pkg::IDX_W-1:0]      iss_row;
  logic [bmma_pkg::IDX_W-1:0]      iss_k;

  logic                            s_accept;
  bmma_pkg::opcode_t               opcode;
  logic [bmma_pkg::ROW_W-1:0]      in_row;
  logic [bmma_pkg::ROW_W-1:0]      in_col;
  logic                            in_range;
  logic                            ld_en;
  logic                            clr;
  logic                            out_free;
  logic                            row_end;
  logic                            all_end;

  logic [bmma_pkg::ADDR_W-1:0]     wr_addr;
  logic [bmma_pkg::ADDR_W-1:0]     rd_addr;
  logic [bmma_pkg::DATA_W-1:0]     a_rd;

  bmma_pkg::ld_t                   ld;
  bmma_pkg::tok_t                  tok_link [bmma_pkg::MAX_DIM];
  logic [bmma_pkg::DATA_W-1:0]     c_rd [bmma_pkg::MAX_DIM];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign opcode    = bmma_pkg::opcode_t'(s_tuser);
  assign in_row    = s_tdata[2:0];
  assign in_col    = s_tdata[5:3];
  assign in_range  = (int'(in_row) < bmma_pkg::MAX_DIM) && (int'(in_col) < bmma_pkg::MAX_DIM);
  assign ld_en     = s_accept && (opcode == bmma_pkg::OP_LOAD) && in_range;
  assign clr       = s_accept && (opcode == bmma_pkg::OP_CLEAR);
  assign out_free  = !m_tvalid || m_tready;
  assign row_end   = (cnt_j == d_last);
  assign all_end   = row_end && (cnt_i == d_last);

  always_comb begin
    priority if (dim == '0) begin
      dim_sat = bmma_pkg::DIM_W'(1);
    end else if (int'(dim) > bmma_pkg::MAX_DIM) begin
      dim_sat = bmma_pkg::DIM_W'(bmma_pkg::MAX_DIM);
    end else begin
      dim_sat = dim;
    end
  end
  assign d_last = bmma_pkg::IDX_W'(dim_sat - bmma_pkg::DIM_W'(1));

  assign wr_addr = bmma_pkg::ADDR_W'(int'(in_row[bmma_pkg::IDX_W-1:0]) * bmma_pkg::MAX_DIM
                                     + int'(in_col[bmma_pkg::IDX_W-1:0]));
  assign rd_addr = bmma_pkg::ADDR_W'(int'(cnt_i) * bmma_pkg::MAX_DIM + int'(cnt_j));

  assign ld.valid = ld_en;
  assign ld.row   = in_row[bmma_pkg::IDX_W-1:0];
  assign ld.col   = in_col[bmma_pkg::IDX_W-1:0];
  assign ld.b     = s_tdata[69:38];

  assign tok_link[0].valid = iss_valid;
  assign tok_link[0].first = iss_first;
  assign tok_link[0].last  = iss_last;
  assign tok_link[0].row   = iss_row;
  assign tok_link[0].k     = iss_k;
  assign tok_link[0].a     = a_rd;

  bmma_ram #(
    .WIDTH(bmma_pkg::DATA_W),
    .DEPTH(bmma_pkg::MAX_DIM * bmma_pkg::MAX_DIM)
  ) u_a_ram (
    .clk    (clk),
    .wr_en  (ld_en),
    .wr_addr(wr_addr),
    .wr_data(s_tdata[37:6]),
    .rd_en  (state == ST_MAC),
    .rd_addr(rd_addr),
    .rd_data(a_rd)
  );

  for (genvar g = 0; g < bmma_pkg::MAX_DIM; g++) begin : g_cell
    if (g < bmma_pkg::MAX_DIM - 1) begin : g_mid
      bmma_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .col_id (bmma_pkg::IDX_W'(g)),
        .d_last (d_last),
        .ld     (ld),
        .clr    (clr),
        .tok_in (tok_link[g]),
        .tok_out(tok_link[g+1]),
        .rd_row (cnt_i),
        .rd_data(c_rd[g])
      );
    end else begin : g_end
      bmma_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .col_id (bmma_pkg::IDX_W'(g)),
        .d_last (d_last),
        .ld     (ld),
        .clr    (clr),
        .tok_in (tok_link[g]),
        .tok_out(),
        .rd_row (cnt_i),
        .rd_data(c_rd[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dim       <= bmma_pkg::DIM_RESET;
      iss_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        dim <= cfg_data;
      end
      iss_valid <= (state == ST_MAC);
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt_i <= '0;
          cnt_j <= '0;
          if (s_accept && opcode == bmma_pkg::OP_MAC) begin
            state <= ST_MAC;
          end else if (s_accept && opcode == bmma_pkg::OP_EMIT) begin
            state <= ST_EMIT;
          end
        end
        ST_MAC: begin
          iss_row   <= cnt_i;
          iss_k     <= cnt_j;
          iss_first <= (cnt_j == '0);
          iss_last  <= row_end;
          cnt_j     <= row_end ? '0 : cnt_j + 1'b1;
          if (row_end) begin
            cnt_i <= cnt_i + 1'b1;
          end
          if (all_end) begin
            state <= ST_DRAIN;
            drain <= bmma_pkg::DRAIN_W'(bmma_pkg::DRAIN_CYC);
          end
        end
        ST_DRAIN: begin
          drain <= drain - 1'b1;
          if (drain == '0) begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tdata  <= {2'b00, bmma_pkg::ROW_W'(cnt_j), bmma_pkg::ROW_W'(cnt_i),
                         c_rd[cnt_j]};
            m_tlast  <= all_end;
            cnt_j    <= row_end ? '0 : cnt_j + 1'b1;
            if (row_end) begin
              cnt_i <= cnt_i + 1'b1;
            end
            if (all_end) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: verif/tb_block_matrix_multiply_accumulate.sv
// testbench of the block matrix multiply-accumulate: directed table and random words
module tb_block_matrix_multiply_accumulate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS        = bmma_pkg::MAX_DIM * bmma_pkg::MAX_DIM;
  localparam int GAP_MAX      = 14;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 2000;
  localparam int TOTAL_WORDS  = 370;

  typedef struct packed {
    logic [bmma_pkg::DATA_W-1:0] c;
    logic [2:0]                  row;
    logic [2:0]                  col;
    logic                        last;
  } c_word_t;

  typedef struct {
    bit                          is_cfg;
    bmma_pkg::opcode_t           op;
    logic [2:0]                  r;
    logic [2:0]                  c;
    logic [bmma_pkg::DATA_W-1:0] a;
    logic [bmma_pkg::DATA_W-1:0] b;
    logic [bmma_pkg::DIM_W-1:0]  dim;
    bit                          known;
    logic [bmma_pkg::DATA_W-1:0] known_c;
  } step_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [bmma_pkg::S_DATA_W-1:0] s_tdata   = '0;
  logic [1:0]                    s_tuser   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [bmma_pkg::M_DATA_W-1:0] m_tdata;
  logic                          m_tlast;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bmma_pkg::DIM_W-1:0]    cfg_data  = '0;

  logic [bmma_pkg::DATA_W-1:0] a_mem [CELLS];
  logic [bmma_pkg::DATA_W-1:0] b_mem [CELLS];
  logic [bmma_pkg::DATA_W-1:0] c_acc [CELLS];
  bit                          written [CELLS];
  logic [bmma_pkg::DIM_W-1:0]  dim_reg;

  c_word_t pending_c[$];
  step_t   steps[$];
  int      fails = 0;
  int      sent = 0;
  int      stall_cycles = 0;
  int      rx_wait = 0;
  bit      quiet = 1'b0;

  block_matrix_multiply_accumulate dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    if (quiet) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic int active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > bmma_pkg::MAX_DIM) return bmma_pkg::MAX_DIM;
    return int'(dim_reg);
  endfunction

  function automatic logic [bmma_pkg::DATA_W-1:0] rand_word();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return bmma_pkg::DATA_W'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // update the expected state for one accepted word and queue its results
  function automatic void apply_word(bmma_pkg::opcode_t op, logic [2:0] r, logic [2:0] c,
                                     logic [bmma_pkg::DATA_W-1:0] a,
                                     logic [bmma_pkg::DATA_W-1:0] b,
                                     bit known, logic [bmma_pkg::DATA_W-1:0] known_c);
    int d;
    int idx;
    logic [bmma_pkg::DATA_W-1:0] sum;
    c_word_t w;
    d = active_dim();
    case (op)
      bmma_pkg::OP_LOAD: begin
        idx = int'(r) * bmma_pkg::MAX_DIM + int'(c);
        a_mem[idx] = a;
        b_mem[idx] = b;
        written[idx] = 1'b1;
      end
      bmma_pkg::OP_MAC: begin
        for (int i = 0; i < d; i++) begin
          for (int j = 0; j < d; j++) begin
            sum = '0;
            for (int k = 0; k < d; k++) begin
              sum = sum + a_mem[i * bmma_pkg::MAX_DIM + k] * b_mem[k * bmma_pkg::MAX_DIM + j];
            end
            c_acc[i * bmma_pkg::MAX_DIM + j] = c_acc[i * bmma_pkg::MAX_DIM + j] + sum;
          end
        end
      end
      bmma_pkg::OP_CLEAR: begin
        foreach (c_acc[n]) c_acc[n] = '0;
      end
      default: begin
        for (int i = 0; i < d; i++) begin
          for (int j = 0; j < d; j++) begin
            w.c    = known ? known_c : c_acc[i * bmma_pkg::MAX_DIM + j];
            w.row  = 3'(i);
            w.col  = 3'(j);
            w.last = (i == d - 1) && (j == d - 1);
            pending_c.push_back(w);
          end
        end
      end
    endcase
  endfunction

  task automatic send_word(bmma_pkg::opcode_t op, logic [2:0] r, logic [2:0] c,
                           logic [bmma_pkg::DATA_W-1:0] a, logic [bmma_pkg::DATA_W-1:0] b,
                           bit known, logic [bmma_pkg::DATA_W-1:0] known_c);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, b, a, c, r};
    do @(posedge clk); while (!s_tready);
    apply_word(op, r, c, a, b, known, known_c);
    sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_c.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(logic [bmma_pkg::DIM_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dim_reg = v;
  endtask

  // loads whatever the next multiply-accumulate would read unwritten
  task automatic fill_active();
    int d;
    d = active_dim();
    for (int i = 0; i < d; i++) begin
      for (int k = 0; k < d; k++) begin
        if (!written[i * bmma_pkg::MAX_DIM + k]) begin
          send_word(bmma_pkg::OP_LOAD, 3'(i), 3'(k), rand_word(), rand_word(), 1'b0, '0);
        end
      end
    end
  endtask

  function automatic void add_step(bit is_cfg, bmma_pkg::opcode_t op,
                                   logic [2:0] r, logic [2:0] c,
                                   logic [bmma_pkg::DATA_W-1:0] a,
                                   logic [bmma_pkg::DATA_W-1:0] b,
                                   logic [bmma_pkg::DIM_W-1:0] dim, bit known,
                                   logic [bmma_pkg::DATA_W-1:0] known_c);
    step_t st;
    st.is_cfg  = is_cfg;
    st.op      = op;
    st.r       = r;
    st.c       = c;
    st.a       = a;
    st.b       = b;
    st.dim     = dim;
    st.known   = known;
    st.known_c = known_c;
    steps.push_back(st);
  endfunction

  function automatic logic [bmma_pkg::DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return bmma_pkg::DIM_W'($urandom_range(bmma_pkg::MAX_DIM + 1, 15));
      2: return bmma_pkg::DIM_W'(bmma_pkg::MAX_DIM);
      3: return 4'd15;
      default: return bmma_pkg::DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // output side: random stalls, checks each word against the oldest expectation
  always @(posedge clk) begin
    c_word_t w;
    if (m_tvalid && m_tready) begin
      if (pending_c.size() == 0) begin
        if (fails < 10) begin
          $display("unexpected word: c=%h row=%0d col=%0d last=%b",
                   m_tdata[31:0], m_tdata[34:32], m_tdata[37:35], m_tlast);
        end
        fails++;
      end else begin
        w = pending_c.pop_front();
        if (m_tdata[31:0] !== w.c || m_tdata[34:32] !== w.row ||
            m_tdata[37:35] !== w.col || m_tlast !== w.last) begin
          if (fails < 10) begin
            $display("mismatch: exp c=%h row=%0d col=%0d last=%b / got %h %0d %0d %b",
                     w.c, w.row, w.col, w.last,
                     m_tdata[31:0], m_tdata[34:32], m_tdata[37:35], m_tlast);
          end
          fails++;
        end
      end
      rx_wait = draw_gap();
      if (rx_wait != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (rx_wait > 0) rx_wait--;
      if (rx_wait == 0) m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int phase_len;
    int pick;
    foreach (c_acc[n]) begin
      a_mem[n] = '0;
      b_mem[n] = '0;
      c_acc[n] = '0;
      written[n] = 1'b0;
    end
    dim_reg = bmma_pkg::DIM_RESET;

    // emit after reset, extremes at d=1, saturated and zero dimensions, d=2 accumulation
    add_step(1'b0, bmma_pkg::OP_EMIT, 3'd0, 3'd0, '0, '0, '0, 1'b1, 32'h0000_0000);
    add_step(1'b1, bmma_pkg::OP_LOAD, 3'd0, 3'd0, '0, '0, 4'd1, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_LOAD, 3'd0, 3'd0, 32'h7fff_ffff, 32'h7fff_ffff, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_LOAD, 3'd7, 3'd7, 32'h8000_0000, 32'h8000_0000, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_MAC, 3'd0, 3'd0, '0, '0, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_EMIT, 3'd0, 3'd0, '0, '0, '0, 1'b1, 32'h0000_0001);
    add_step(1'b0, bmma_pkg::OP_LOAD, 3'd0, 3'd0, 32'h8000_0000, 32'hffff_ffff, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_MAC, 3'd0, 3'd0, '0, '0, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_EMIT, 3'd0, 3'd0, '0, '0, '0, 1'b1, 32'h8000_0001);
    add_step(1'b0, bmma_pkg::OP_CLEAR, 3'd7, 3'd7, 32'hffff_ffff, 32'hffff_ffff, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_EMIT, 3'd0, 3'd0, '0, '0, '0, 1'b1, 32'h0000_0000);
    add_step(1'b1, bmma_pkg::OP_LOAD, 3'd0, 3'd0, '0, '0, 4'd0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_EMIT, 3'd0, 3'd0, '0, '0, '0, 1'b1, 32'h0000_0000);
    add_step(1'b1, bmma_pkg::OP_LOAD, 3'd0, 3'd0, '0, '0, 4'd2, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_LOAD, 3'd0, 3'd1, 32'h0000_0000, 32'h0000_0000, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_LOAD, 3'd1, 3'd0, 32'h1234_5678, 32'hffff_ffff, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_LOAD, 3'd1, 3'd1, 32'hffff_ffff, 32'h0000_0001, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_MAC, 3'd0, 3'd0, '0, '0, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_EMIT, 3'd0, 3'd0, '0, '0, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_MAC, 3'd0, 3'd0, '0, '0, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_MAC, 3'd0, 3'd0, '0, '0, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_EMIT, 3'd0, 3'd0, '0, '0, '0, 1'b0, '0);
    add_step(1'b1, bmma_pkg::OP_LOAD, 3'd0, 3'd0, '0, '0, 4'd15, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_EMIT, 3'd0, 3'd0, '0, '0, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_CLEAR, 3'd0, 3'd0, '0, '0, '0, 1'b0, '0);
    add_step(1'b0, bmma_pkg::OP_EMIT, 3'd0, 3'd0, '0, '0, '0, 1'b1, 32'h0000_0000);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[n]) begin
      if (steps[n].is_cfg) begin
        write_dim(steps[n].dim);
      end else begin
        send_word(steps[n].op, steps[n].r, steps[n].c, steps[n].a, steps[n].b,
                  steps[n].known, steps[n].known_c);
      end
    end

    while (sent < TOTAL_WORDS) begin
      write_dim(pick_dim());
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(8, 30);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_word(bmma_pkg::OP_LOAD, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    rand_word(), rand_word(), 1'b0, '0);
        end else if (pick < 65) begin
          fill_active();
          send_word(bmma_pkg::OP_MAC, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    rand_word(), rand_word(), 1'b0, '0);
        end else if (pick < 70) begin
          send_word(bmma_pkg::OP_CLEAR, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    rand_word(), rand_word(), 1'b0, '0);
        end else begin
          send_word(bmma_pkg::OP_EMIT, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    rand_word(), rand_word(), 1'b0, '0);
        end
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end

    wait_idle();
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
